FILE: src/go_to_goal_controller_assert.svh
`ifndef GO_TO_GOAL_CONTROLLER_ASSERT_SVH
`define GO_TO_GOAL_CONTROLLER_ASSERT_SVH

// Combinational implication, checked at every edge out of reset.
`define GTG_ASSERT_HOLDS(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication.
`define GTG_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: src/gtg_pkg.sv
package gtg_pkg;

    localparam int FRAC_BITS     = 10;
    localparam int CORDIC_STAGES = 16;

    localparam int POS_W  = 16;
    localparam int DIFF_W = POS_W + 1;
    localparam int OUT_W  = 15;
    localparam int GAIN_W = 16;

    // distance path
    localparam int SQX_W  = 2 * DIFF_W - 2;
    localparam int SQ_W   = SQX_W + 1;
    localparam int ROOT_W = (SQ_W + 1) / 2;
    localparam int SQP_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;
    localparam int PROD_W = GAIN_W + ROOT_W;
    localparam int SPD_W  = PROD_W - FRAC_BITS;

    localparam int NEAR_TH = ((1 << FRAC_BITS) + 5) / 10;
    localparam int TURN_TH = ((2 << FRAC_BITS) + 5) / 10;
    localparam logic [SQ_W-1:0] NEAR_SQ = SQ_W'(NEAR_TH * NEAR_TH);

    // bearing path
    localparam int PRESCALE_SH = 20;
    localparam int CW          = 40;
    localparam int ZW          = 34;
    localparam int ERR_W       = ZW + 1;
    localparam int RND_SH      = 30 - FRAC_BITS;
    localparam logic signed [ZW-1:0] RND_HALF = ZW'(64'sd1 << (29 - FRAC_BITS));
    localparam logic signed [ZW-1:0] PI_Q30   = 34'sd3373259426;
    localparam logic [OUT_W-1:0]     SAT_MAX  = {OUT_W{1'b1}};

    localparam logic signed [ZW-1:0] ATAN_Q30 [0:23] = '{
        34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
        34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
        34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
        34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
        34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
        34'sd1024,      34'sd512,       34'sd256,       34'sd128
    };

    // pipeline depths, both units padded to the longer one
    localparam int CO_LAT   = CORDIC_STAGES + 3;
    localparam int SQ_LAT   = ROOT_W + 2;
    localparam int CORE_LAT = (CO_LAT > SQ_LAT) ? CO_LAT : SQ_LAT;

    localparam int CFG_IDX_W = 4;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_X  = 4'd0,
        CFG_TARGET_Y  = 4'd1,
        CFG_GAIN      = 4'd2,
        CFG_MAX_SPEED = 4'd3
    } gtg_cfg_t;

    typedef struct packed {
        logic             turn;
        logic [OUT_W-1:0] mag;
    } gtg_dir_t;

    typedef struct packed {
        logic              near;
        logic [ROOT_W-1:0] root;
    } gtg_dist_t;

endpackage

FILE: src/go_to_goal_controller.sv
// Go-to-goal controller: one pose request (x, y, heading) in, one command
// (turn_rate, forward_speed) out, all Q.10 fixed point. The pose is compared
// against the configured target; within 0.1 of it both commands are zero,
// else a bearing error (atan2 minus heading, not wrapped) above 0.2 gives a
// turn in place at |error| (saturated), otherwise the robot drives at
// gain * distance capped at max_speed. A new pose is accepted every cycle
// unless both output slots hold data. The input stage feeds the CORDIC
// vectoring pipeline (pre-rotation, 16 stages, rounding, threshold), running
// beside an equally deep square plus 17-stage square-root pipeline, then the
// gain product stage and the output register. A two-entry output buffer keeps
// the input open while one result waits. Targets, gain and speed cap are written
// through the cfg port while the block is idle, a rule for the user that the
// block does not enforce; reset gives target (1.0, 1.0), gain 1.0, max_speed 3.0.
module go_to_goal_controller
    import gtg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // slave stream: [15:0] pos_x, [31:16] pos_y, [47:32] heading
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [47:0]          s_axis_tdata,
    // master stream: [14:0] turn_rate, [29:15] forward_speed, [31:30] zero
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [31:0]          m_axis_tdata,
    // config write
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

`include "go_to_goal_controller_assert.svh"

    localparam int VLD_N = CORE_LAT + 2;

    logic signed [POS_W-1:0]  target_x_reg, target_y_reg;
    logic [GAIN_W-1:0]        gain_reg;
    logic [OUT_W-1:0]         max_speed_reg;

    logic signed [POS_W-1:0]  pos_x, pos_y, heading;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dx_next, dy_next;
    logic signed [POS_W-1:0]  hd_reg;
    logic                     vld_reg [0:VLD_N-1];
    logic                     en, push;

    gtg_dir_t                 dir;
    gtg_dist_t                dist_info;

    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic [OUT_W-1:0]         turn_reg, turn_next;
    logic                     drive_reg;
    logic [SPD_W-1:0]         spd_full;
    logic [OUT_W-1:0]         res_turn, res_fwd;

    logic                     out_vld_reg, skid_vld_reg;
    logic [OUT_W-1:0]         out_turn_reg, out_fwd_reg;
    logic [OUT_W-1:0]         skid_turn_reg, skid_fwd_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_x_reg  <= 16'sd1024;
            target_y_reg  <= 16'sd1024;
            gain_reg      <= 16'd1024;
            max_speed_reg <= 15'd3072;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_TARGET_X:  target_x_reg  <= cfg_data;
                CFG_TARGET_Y:  target_y_reg  <= cfg_data;
                CFG_GAIN:      gain_reg      <= cfg_data;
                CFG_MAX_SPEED: max_speed_reg <= cfg_data[OUT_W-1:0];
                default:       ;
            endcase
        end
    end

    // whole pipe moves together; it only halts when both output slots hold data
    assign en            = !skid_vld_reg;
    assign s_axis_tready = en;
    assign push          = en && vld_reg[VLD_N-1];

    assign pos_x   = s_axis_tdata[15:0];
    assign pos_y   = s_axis_tdata[31:16];
    assign heading = s_axis_tdata[47:32];
    assign dx_next = {target_x_reg[POS_W-1], target_x_reg} - {pos_x[POS_W-1], pos_x};
    assign dy_next = {target_y_reg[POS_W-1], target_y_reg} - {pos_y[POS_W-1], pos_y};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < VLD_N; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= s_axis_tvalid;
            for (int k = 1; k < VLD_N; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            hd_reg <= heading;
        end
    end

    gtg_cordic u_cordic (
        .clk  (clk),
        .en   (en),
        .dx   (dx_reg),
        .dy   (dy_reg),
        .head (hd_reg),
        .dir  (dir)
    );

    gtg_isqrt u_isqrt (
        .clk       (clk),
        .en        (en),
        .dx        (dx_reg),
        .dy        (dy_reg),
        .dist_info (dist_info)
    );

    // decide mode, form gain * distance
    assign prod_next = PROD_W'(gain_reg) * PROD_W'(dist_info.root);
    assign turn_next = (!dist_info.near && dir.turn) ? dir.mag : '0;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            turn_reg  <= turn_next;
            drive_reg <= !dist_info.near && !dir.turn;
        end
    end

    assign spd_full = prod_reg[PROD_W-1:FRAC_BITS];
    assign res_turn = turn_reg;

    always_comb
    begin
        if (!drive_reg)
        begin
            res_fwd = '0;
        end
        else if (spd_full > SPD_W'(max_speed_reg))
        begin
            res_fwd = max_speed_reg;
        end
        else
        begin
            res_fwd = spd_full[OUT_W-1:0];
        end
    end

    // output register plus skid slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || m_axis_tready)
        begin
            if (skid_vld_reg)
            begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end
            else
            begin
                out_vld_reg <= push;
            end
        end
        else if (push)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || m_axis_tready)
        begin
            if (skid_vld_reg)
            begin
                out_turn_reg <= skid_turn_reg;
                out_fwd_reg  <= skid_fwd_reg;
            end
            else if (push)
            begin
                out_turn_reg <= res_turn;
                out_fwd_reg  <= res_fwd;
            end
        end
        else if (push)
        begin
            skid_turn_reg <= res_turn;
            skid_fwd_reg  <= res_fwd;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {2'b00, out_fwd_reg, out_turn_reg};

    `GTG_ASSERT_HOLDS(a_skid_behind_out, clk, rst_n, skid_vld_reg, out_vld_reg,
        "skid slot full while output register empty")
    `GTG_ASSERT_HOLDS(a_one_command, clk, rst_n, out_vld_reg && (out_turn_reg != '0),
        out_fwd_reg == '0, "turn and forward commands both nonzero")
    `GTG_ASSERT_HOLDS(a_speed_capped, clk, rst_n, out_vld_reg,
        out_fwd_reg <= max_speed_reg, "forward speed above cap")
    `GTG_ASSERT_NEXT(a_skid_holds, clk, rst_n, skid_vld_reg && !m_axis_tready,
        skid_vld_reg, "buffered result dropped while output stalled")

endmodule

FILE: src/gtg_cordic.sv
module gtg_cordic
    import gtg_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [DIFF_W-1:0] dx,
    input  logic signed [DIFF_W-1:0] dy,
    input  logic signed [POS_W-1:0]  head,
    output gtg_dir_t                 dir
);

    localparam int PAD = CORE_LAT - CO_LAT;

    logic signed [CW-1:0]    x_reg [0:CORDIC_STAGES];
    logic signed [CW-1:0]    y_reg [0:CORDIC_STAGES];
    logic signed [ZW-1:0]    z_reg [0:CORDIC_STAGES];
    logic signed [POS_W-1:0] h_reg [0:CORDIC_STAGES];

    logic signed [CW-1:0] x_next [0:CORDIC_STAGES-1];
    logic signed [CW-1:0] y_next [0:CORDIC_STAGES-1];
    logic signed [ZW-1:0] z_next [0:CORDIC_STAGES-1];

    logic signed [CW-1:0]    xs, ys, x0_next, y0_next;
    logic signed [ZW-1:0]    z0_next;
    logic signed [ZW-1:0]    bear_reg, bear_next;
    logic signed [POS_W-1:0] hb_reg;
    logic signed [ERR_W-1:0] err;
    logic [ERR_W-1:0]        err_abs;
    gtg_dir_t                dir_reg, dir_next;

    // left half-plane: flip the vector, start from +/- pi
    always_comb
    begin
        xs = {{(CW - DIFF_W - PRESCALE_SH){dx[DIFF_W-1]}}, dx, {PRESCALE_SH{1'b0}}};
        ys = {{(CW - DIFF_W - PRESCALE_SH){dy[DIFF_W-1]}}, dy, {PRESCALE_SH{1'b0}}};
        if (dx[DIFF_W-1])
        begin
            x0_next = -xs;
            y0_next = -ys;
            z0_next = dy[DIFF_W-1] ? -PI_Q30 : PI_Q30;
        end
        else
        begin
            x0_next = xs;
            y0_next = ys;
            z0_next = '0;
        end
    end

    always_comb
    begin
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            if (!y_reg[i][CW-1])
            begin
                x_next[i] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i] = z_reg[i] + ATAN_Q30[i];
            end
            else
            begin
                x_next[i] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i] = z_reg[i] - ATAN_Q30[i];
            end
        end
    end

    assign bear_next = (z_reg[CORDIC_STAGES] + RND_HALF) >>> RND_SH;

    always_comb
    begin
        err     = ERR_W'(bear_reg) - ERR_W'(hb_reg);
        err_abs = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
        dir_next.turn = (err_abs > ERR_W'(TURN_TH));
        dir_next.mag  = (err_abs > ERR_W'(SAT_MAX)) ? SAT_MAX : err_abs[OUT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= x0_next;
            y_reg[0] <= y0_next;
            z_reg[0] <= z0_next;
            h_reg[0] <= head;
            for (int i = 0; i < CORDIC_STAGES; i++)
            begin
                x_reg[i+1] <= x_next[i];
                y_reg[i+1] <= y_next[i];
                z_reg[i+1] <= z_next[i];
                h_reg[i+1] <= h_reg[i];
            end
            bear_reg <= bear_next;
            hb_reg   <= h_reg[CORDIC_STAGES];
            dir_reg  <= dir_next;
        end
    end

    generate
        if (PAD > 0)
        begin : g_pad
            gtg_dir_t pad_reg [0:PAD-1];
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    pad_reg[0] <= dir_reg;
                    for (int k = 1; k < PAD; k++)
                    begin
                        pad_reg[k] <= pad_reg[k-1];
                    end
                end
            end
            assign dir = pad_reg[PAD-1];
        end
        else
        begin : g_nopad
            assign dir = dir_reg;
        end
    endgenerate

endmodule

FILE: src/gtg_isqrt.sv
module gtg_isqrt
    import gtg_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [DIFF_W-1:0] dx,
    input  logic signed [DIFF_W-1:0] dy,
    output gtg_dist_t                dist_info
);

    localparam int PAD = CORE_LAT - SQ_LAT;

    logic [SQX_W-1:0]  sqx_reg, sqy_reg;
    logic [SQP_W-1:0]  n_reg    [0:ROOT_W];
    logic [REM_W-1:0]  rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0] root_reg [0:ROOT_W];
    logic              near_reg [0:ROOT_W];

    logic [REM_W-1:0]  rem_t     [0:ROOT_W-1];
    logic [REM_W-1:0]  trial     [0:ROOT_W-1];
    logic [REM_W-1:0]  rem_next  [0:ROOT_W-1];
    logic [ROOT_W-1:0] root_next [0:ROOT_W-1];

    logic signed [2*DIFF_W-1:0] px, py;
    logic [SQ_W-1:0]            sum;
    gtg_dist_t                  dist_last;

    assign px  = dx * dx;
    assign py  = dy * dy;
    assign sum = SQ_W'(sqx_reg) + SQ_W'(sqy_reg);

    // two radicand bits per stage, restoring
    always_comb
    begin
        for (int j = 0; j < ROOT_W; j++)
        begin
            rem_t[j] = {rem_reg[j][REM_W-3:0], n_reg[j][SQP_W-1 -: 2]};
            trial[j] = {root_reg[j], 2'b01};
            if (rem_t[j] >= trial[j])
            begin
                rem_next[j]  = rem_t[j] - trial[j];
                root_next[j] = {root_reg[j][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[j]  = rem_t[j];
                root_next[j] = {root_reg[j][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg     <= px[SQX_W-1:0];
            sqy_reg     <= py[SQX_W-1:0];
            n_reg[0]    <= SQP_W'(sum);
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            near_reg[0] <= (sum <= NEAR_SQ);
            for (int j = 0; j < ROOT_W; j++)
            begin
                n_reg[j+1]    <= {n_reg[j][SQP_W-3:0], 2'b00};
                rem_reg[j+1]  <= rem_next[j];
                root_reg[j+1] <= root_next[j];
                near_reg[j+1] <= near_reg[j];
            end
        end
    end

    always_comb
    begin
        dist_last.near = near_reg[ROOT_W];
        dist_last.root = root_reg[ROOT_W];
    end

    generate
        if (PAD > 0)
        begin : g_pad
            gtg_dist_t pad_reg [0:PAD-1];
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    pad_reg[0] <= dist_last;
                    for (int k = 1; k < PAD; k++)
                    begin
                        pad_reg[k] <= pad_reg[k-1];
                    end
                end
            end
            assign dist_info = pad_reg[PAD-1];
        end
        else
        begin : g_nopad
            assign dist_info = dist_last;
        end
    endgenerate

endmodule

FILE: tb/go_to_goal_controller_test.sv
module go_to_goal_controller_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gtg_pkg::*;

    localparam int     PIPE_LAT  = 21;
    localparam int     DRAIN     = PIPE_LAT + 8;
    localparam int     MAX_WAIT  = 14;
    localparam longint NEAR_LSB  = ((64'sd1 << FRAC_BITS) + 5) / 10;
    localparam longint TURN_LSB  = ((64'sd2 << FRAC_BITS) + 5) / 10;
    localparam longint CMD_MAX   = (64'sd1 << 15) - 1;
    localparam longint PI_ANGLE  = 64'sd3373259426;
    localparam longint PRE_SCALE = 64'sd1 << 20;

    // arctan(2^-i) in Q30
    localparam longint ARCTAN_Q30 [0:23] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128
    };

    typedef struct packed {
        logic [14:0] turn_rate;
        logic [14:0] forward_speed;
    } drive_cmd_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [47:0]          s_axis_tdata;   // [15:0] pos_x, [31:16] pos_y, [47:32] heading
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [31:0]          m_axis_tdata;   // [14:0] turn_rate, [29:15] forward_speed
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;

    // controller settings as the block should hold them
    longint goal_x = 1024;
    longint goal_y = 1024;
    longint speed_gain = 1024;
    longint speed_cap = 3072;

    drive_cmd_t expected_cmds [$];
    int         mismatch_count = 0;
    bit         send_idle = 1'b1;
    bit         recv_idle = 1'b1;

    go_to_goal_controller dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("FAIL go_to_goal_controller");
        $finish;
    end

    function automatic longint cordic_bearing(input longint dx, input longint dy);
        longint x, y, z, nx;
        x = dx * PRE_SCALE;
        y = dy * PRE_SCALE;
        z = 0;
        if (dx < 0)
        begin
            z = (dy >= 0) ? PI_ANGLE : -PI_ANGLE;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++)
        begin
            if (y >= 0)
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + ARCTAN_Q30[i];
            end
            else
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - ARCTAN_Q30[i];
            end
            x = nx;
        end
        return (z + (64'sd1 << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned root, probe;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > n)
            probe >>= 2;
        while (probe != 0)
        begin
            if (n >= root + probe)
            begin
                n    = n - (root + probe);
                root = (root >> 1) + probe;
            end
            else
                root >>= 1;
            probe >>= 2;
        end
        return root;
    endfunction

    function automatic drive_cmd_t predict_cmd(input logic signed [15:0] px,
                                               input logic signed [15:0] py,
                                               input logic signed [15:0] hd);
        longint     dx, dy, sq, err, spd;
        drive_cmd_t cmd;
        cmd = '0;
        dx  = goal_x - longint'(px);
        dy  = goal_y - longint'(py);
        sq  = dx * dx + dy * dy;
        if (sq > NEAR_LSB * NEAR_LSB)
        begin
            err = cordic_bearing(dx, dy) - longint'(hd);
            if (err < 0)
                err = -err;
            if (err > TURN_LSB)
                cmd.turn_rate = (err > CMD_MAX) ? CMD_MAX[14:0] : err[14:0];
            else
            begin
                spd = (speed_gain * longint'(int_sqrt(sq))) >>> FRAC_BITS;
                if (spd > speed_cap)
                    spd = speed_cap;
                cmd.forward_speed = spd[14:0];
            end
        end
        return cmd;
    endfunction

    function automatic logic signed [15:0] sat16(input longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return 16'(v);
    endfunction

    // heading that points at the goal, shifted by offset
    function automatic logic signed [15:0] aim_heading(input logic signed [15:0] px,
                                                       input logic signed [15:0] py,
                                                       input longint offset);
        return sat16(cordic_bearing(goal_x - longint'(px), goal_y - longint'(py)) + offset);
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        $display("%0t mismatch %s: expected %0d, got %0d", $realtime, what, want, got);
        mismatch_count++;
    endtask

    task automatic send_pose(input logic signed [15:0] px, input logic signed [15:0] py,
                             input logic signed [15:0] hd);
        int gap;
        gap = send_idle ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {hd, py, px};
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_cmds.push_back(predict_cmd(px, py, hd));
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_cmds.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_TARGET_X:  goal_x = longint'(signed'(val));
            CFG_TARGET_Y:  goal_y = longint'(signed'(val));
            CFG_GAIN:      speed_gain = longint'(val);
            CFG_MAX_SPEED: speed_cap = longint'(val[14:0]);
            default: ;
        endcase
    endtask

    // results come back in order, one per pose
    initial
    begin : cmd_checker
        int         stall;
        drive_cmd_t want;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = recv_idle ? $urandom_range(0, MAX_WAIT) : 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            if (expected_cmds.size() == 0)
                report_mismatch("command with no pose pending", 64'sd0,
                                longint'(m_axis_tdata));
            else
            begin
                want = expected_cmds.pop_front();
                if (m_axis_tdata[14:0] !== want.turn_rate)
                    report_mismatch("turn_rate", longint'(want.turn_rate),
                                    longint'(m_axis_tdata[14:0]));
                if (m_axis_tdata[29:15] !== want.forward_speed)
                    report_mismatch("forward_speed", longint'(want.forward_speed),
                                    longint'(m_axis_tdata[29:15]));
            end
        end
    end

    // reset settings: goal (1.0, 1.0), gain 1.0, cap 3.0
    task automatic test_reset_values();
        send_idle = 1'b1;
        recv_idle = 1'b1;
        send_pose(16'sd1024, 16'sd1024, 16'sd0);              // on the goal
        send_pose(16'sd922, 16'sd1024, 16'sd0);               // just inside the near radius
        send_pose(16'sd921, 16'sd1024, 16'sd0);               // just outside, straight ahead
        send_pose(16'sd952, 16'sd952, 16'sd800);              // diagonal, inside
        send_pose(16'sd952, 16'sd951, aim_heading(16'sd952, 16'sd951, 64'sd0));
        send_pose(16'sd1524, 16'sd1024, 16'sd0);              // goal behind, dy zero
        send_pose(16'sd1524, 16'sd1524, 16'sd0);              // behind, below
        send_pose(16'sd1524, 16'sd524, 16'sd0);               // behind, above
        send_pose(16'sd1024, 16'sd24, 16'sd0);                // straight up
        send_pose(16'sd1024, 16'sd2024, 16'sd0);              // straight down
        // bearing error right at the turn threshold, both sides
        send_pose(16'sd24, 16'sd300, aim_heading(16'sd24, 16'sd300, -TURN_LSB));
        send_pose(16'sd24, 16'sd300, aim_heading(16'sd24, 16'sd300, -TURN_LSB - 1));
        send_pose(16'sd24, 16'sd300, aim_heading(16'sd24, 16'sd300, TURN_LSB));
        send_pose(16'sd24, 16'sd300, aim_heading(16'sd24, 16'sd300, TURN_LSB + 1));
        // turn rate saturation
        send_pose(16'sd0, 16'sd0, 16'sh8000);
        send_pose(16'sd2000, 16'sd2000, 16'sh7FFF);
        send_pose(16'sh8000, 16'sh8000, aim_heading(16'sh8000, 16'sh8000, 64'sd0));
        send_pose(16'sh7FFF, 16'sh7FFF, aim_heading(16'sh7FFF, 16'sh7FFF, 64'sd0));
        send_pose(16'sh8000, 16'sd1024, 16'sd0);              // far ahead, speed capped
        send_pose(16'sd500, 16'sd1024, 16'sd0);               // below the cap
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_TARGET_X, 16'h7FFF);
        write_reg(CFG_TARGET_Y, 16'h8000);
        write_reg(CFG_GAIN, 16'hFFFF);
        write_reg(CFG_MAX_SPEED, 16'hFFFF);
        send_pose(16'sh8000, 16'sh7FFF, aim_heading(16'sh8000, 16'sh7FFF, 64'sd0));
        send_pose(16'sh7FFF, 16'sh8000, 16'sd0);
        send_pose(16'sh8000, 16'sh8000, aim_heading(16'sh8000, 16'sh8000, 64'sd0));
        send_pose(16'sh7FFF, 16'sh7FFF, aim_heading(16'sh7FFF, 16'sh7FFF, 64'sd0));
        send_pose(16'sh7F00, 16'sh8000, 16'sd0);
        write_reg(CFG_GAIN, 16'h0000);
        send_pose(16'sd0, 16'sd0, aim_heading(16'sd0, 16'sd0, 64'sd0));
        write_reg(CFG_GAIN, 16'h0400);
        write_reg(CFG_MAX_SPEED, 16'h0000);
        send_pose(16'sd0, 16'sd0, aim_heading(16'sd0, 16'sd0, 64'sd0));
        write_reg(CFG_TARGET_X, 16'h8000);
        write_reg(CFG_TARGET_Y, 16'h7FFF);
        write_reg(CFG_MAX_SPEED, 16'h7FFF);
        send_pose(16'sh7FFF, 16'sh8000, aim_heading(16'sh7FFF, 16'sh8000, 64'sd0));
        send_pose(16'sh7FFF, 16'sh8000, 16'sh8000);
        send_pose(16'sh8000, 16'sh8000, aim_heading(16'sh8000, 16'sh8000, 64'sd0));
    endtask

    // writes to unmapped indexes must leave the settings alone
    task automatic test_unknown_register();
        for (int k = int'(CFG_MAX_SPEED) + 1; k < (1 << CFG_IDX_W); k++)
            write_reg(CFG_IDX_W'(k), 16'($urandom));
        send_pose(16'sd0, 16'sd0, aim_heading(16'sd0, 16'sd0, 64'sd0));
        send_pose(16'sd100, 16'sd200, 16'sd0);
        send_pose(16'sh8000, 16'sd32000, aim_heading(16'sh8000, 16'sd32000, 64'sd100));
    endtask

    task automatic test_random_traffic(input int phases, input int per_phase);
        int                 sel, mode;
        logic signed [15:0] px, py, hd;
        for (int p = 0; p < phases; p++)
        begin
            case (p % 3)
                0:
                begin
                    write_reg(CFG_TARGET_X, 16'($urandom));
                    write_reg(CFG_TARGET_Y, 16'($urandom));
                end
                1:
                begin
                    write_reg(CFG_TARGET_X, 16'(int'($urandom_range(0, 8192)) - 4096));
                    write_reg(CFG_TARGET_Y, 16'(int'($urandom_range(0, 8192)) - 4096));
                end
                default:
                begin
                    write_reg(CFG_TARGET_X, $urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
                    write_reg(CFG_TARGET_Y, $urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
                end
            endcase
            write_reg(CFG_GAIN, (p % 2) ? 16'($urandom) : 16'($urandom_range(256, 4096)));
            write_reg(CFG_MAX_SPEED, (p == phases - 1) ? 16'h7FFF : 16'($urandom));
            for (int n = 0; n < per_phase; n++)
            begin
                if (n % 50 == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    send_idle = mode[0];
                    recv_idle = mode[1];
                end
                // hold off until the pipeline is empty, then resume
                if (n == per_phase / 2)
                    wait_idle();
                sel = $urandom_range(0, 9);
                if (sel < 2)
                begin
                    px = sat16(goal_x + int'($urandom_range(0, 320)) - 160);
                    py = sat16(goal_y + int'($urandom_range(0, 320)) - 160);
                    hd = 16'($urandom);
                end
                else if (sel < 6)
                begin
                    px = 16'($urandom);
                    py = 16'($urandom);
                    hd = aim_heading(px, py, longint'(int'($urandom_range(0, 600)) - 300));
                end
                else
                begin
                    px = 16'($urandom);
                    py = 16'($urandom);
                    hd = 16'($urandom);
                end
                send_pose(px, py, hd);
            end
        end
    endtask

    initial
    begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= CFG_TARGET_X;
        cfg_data      <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_register_extremes();
        test_unknown_register();
        test_random_traffic(6, 250);

        wait_idle();
        if (mismatch_count == 0)
            $display("PASS go_to_goal_controller");
        else
            $display("FAIL go_to_goal_controller");
        $finish;
    end

endmodule
